>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL. They compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define URC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define URC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define URC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define URC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/urc_pkg.sv
package urc_pkg;

    // Measurement sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TLOW  = 3'd1,
        PH_THIGH = 3'd2,
        PH_CLEAR = 3'd3,
        PH_RISE  = 3'd4,
        PH_HIGH  = 3'd5
    } t_phase;

    // Sensor status codes as seen on o_sensor_status
    typedef enum logic [1:0] {
        ST_READY        = 2'd0,
        ST_READING      = 2'd1,
        ST_ERROR        = 2'd2,
        ST_DISCONNECTED = 2'd3
    } t_status;

    localparam int CFG_W    = 20;
    localparam int TICK_W   = 4;
    localparam int FAIL_W   = 8;
    localparam int DIST_W   = 13;
    localparam int HEALTH_W = 7;
    localparam int WSEL_W   = 15;   // in-range widths fit here (max 23200)

    localparam logic [TICK_W-1:0] LOW_TICKS  = 4'd2;
    localparam logic [TICK_W-1:0] HIGH_TICKS = 4'd10;

    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 20'd30000;

    localparam int US_PER_CM = 58;
    localparam int MIN_WIDTH = 2 * US_PER_CM;
    localparam int MAX_WIDTH = 400 * US_PER_CM;

    // floor(w * 16 / 58) == (w * RECIP) >> RECIP_SHIFT for w <= MAX_WIDTH
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 20;
    localparam logic [RECIP_W-1:0] RECIP = 19'd289263;
    localparam int PROD_W = WSEL_W + RECIP_W;

    localparam logic [FAIL_W-1:0] DISCONNECT_LIMIT = 8'd5;
    localparam logic [FAIL_W-1:0] FAIL_MAX         = 8'd255;
    localparam logic [FAIL_W-1:0] HEALTH_FLOOR     = 8'd10;

    localparam logic [HEALTH_W-1:0] HEALTH_FULL  = 7'd100;
    localparam logic [HEALTH_W-1:0] HEALTH_ERROR = 7'd30;
    localparam logic [HEALTH_W-1:0] HEALTH_NONE  = 7'd0;
    localparam logic [HEALTH_W-1:0] HEALTH_STEP  = 7'd10;

    localparam logic [DIST_W-1:0] DIST_MAX = 13'd6400;

    // One result word
    typedef struct packed {
        logic                trigger;
        logic                done_res;
        logic                valid_res;
        logic [DIST_W-1:0]   distance_cm_q4;
        t_status             sensor_status;
        logic [FAIL_W-1:0]   failure_count;
        logic [HEALTH_W-1:0] health_score;
    } t_result;

endpackage

>>> rtl/core/ultrasonic_ranging_controller_top.sv
// Ultrasonic time-of-flight ranging controller. Each input word is one
// one-microsecond tick: the start request and the sampled echo pin level. Each
// accepted word yields exactly one result word holding the trigger pin level
// for that tick, a done flag on the tick a measurement ends, the distance in
// cm with four fraction bits (only when within 2 to 400 cm), and the sensor
// status, consecutive failure count and health score after that tick.
// A start taken while idle drives trigger low for 2 ticks, high for 10, then
// waits for echo low, its rising edge and its falling edge; if the falling
// edge has not come within timeout_us ticks after the trigger pulse, the
// measurement fails. Throughput is one word per clock: the whole tick update,
// including the constant-reciprocal multiply for the distance, sits between
// the state registers and the result register, so a word is taken every cycle
// while the result side drains. An accepted word's result goes to the result
// register, or to the skid register while that one is held. A two-word output
// buffer (result register plus skid register) lets input be taken while a
// result waits; o_in_stall rises only once both are full. There is no clearing
// pass after reset. timeout_us is written through the configuration port,
// which is always ready; write it only while no words are in flight.
`include "assert_macros.svh"

module ultrasonic_ranging_controller_top #(
    parameter int TIMER_BITS = 20
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // Configuration: timeout_us
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [urc_pkg::CFG_W-1:0]            i_cfg_timeout_us,

    // Tick input
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_start_req,
    input  logic                                 i_echo,

    // Result output
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_trigger,
    output logic                                 o_done_res,
    output logic                                 o_valid_res,
    output logic [urc_pkg::DIST_W-1:0]           o_distance_cm_q4,
    output logic [1:0]                           o_sensor_status,
    output logic [urc_pkg::FAIL_W-1:0]           o_failure_count,
    output logic [urc_pkg::HEALTH_W-1:0]         o_health_score
);

    // Compare width for elapsed time against the 20-bit timeout
    localparam int CMP_W = (TIMER_BITS > urc_pkg::CFG_W) ? TIMER_BITS : urc_pkg::CFG_W;

    // Config
    logic [urc_pkg::CFG_W-1:0]   r_timeout_us;

    // Sequencer state
    urc_pkg::t_phase             r_phase, n_phase;
    logic [urc_pkg::TICK_W-1:0]  r_phase_ticks, n_phase_ticks;
    logic [TIMER_BITS-1:0]       r_elapsed, n_elapsed;
    logic [TIMER_BITS-1:0]       r_echo_width, n_echo_width;
    logic [urc_pkg::FAIL_W-1:0]  r_failures, n_failures;
    urc_pkg::t_status            r_status, n_status;

    // Output buffer
    urc_pkg::t_result            r_out, r_skid, s_res;
    logic                        r_out_valid, r_skid_valid;

    logic                        s_acc;
    logic                        s_out_free;

    // Tick evaluation
    logic                        s_done;
    logic [TIMER_BITS-1:0]       s_width;
    logic [TIMER_BITS-1:0]       s_elapsed_inc;
    logic                        s_in_range;
    logic [urc_pkg::PROD_W-1:0]  s_prod;
    logic [urc_pkg::DIST_W-1:0]  s_dist;
    logic [urc_pkg::HEALTH_W-1:0] s_health;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign s_acc       = i_in_valid & ~r_skid_valid;
    assign s_out_free  = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_us <= urc_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout_us <= i_cfg_timeout_us;
        end
    end

    // Distance: width * 16 / 58 by reciprocal multiply, exact over the valid range
    assign s_in_range = (s_width >= TIMER_BITS'(urc_pkg::MIN_WIDTH)) &&
                        (s_width <= TIMER_BITS'(urc_pkg::MAX_WIDTH));
    assign s_prod = urc_pkg::PROD_W'(s_width[urc_pkg::WSEL_W-1:0]) *
                    urc_pkg::PROD_W'(urc_pkg::RECIP);
    assign s_dist = s_prod[urc_pkg::RECIP_SHIFT +: urc_pkg::DIST_W];

    assign s_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;

    always_comb begin
        n_phase       = r_phase;
        n_phase_ticks = r_phase_ticks;
        n_elapsed     = r_elapsed;
        n_echo_width  = r_echo_width;
        n_failures    = r_failures;
        n_status      = r_status;
        s_done        = 1'b0;
        s_width       = '0;
        s_res         = '0;

        case (r_phase)
            urc_pkg::PH_TLOW: begin
                n_phase_ticks = r_phase_ticks + 1'b1;
                if (n_phase_ticks >= urc_pkg::LOW_TICKS) begin
                    n_phase       = urc_pkg::PH_THIGH;
                    n_phase_ticks = '0;
                end
            end
            urc_pkg::PH_THIGH: begin
                s_res.trigger = 1'b1;
                n_phase_ticks = r_phase_ticks + 1'b1;
                if (n_phase_ticks >= urc_pkg::HIGH_TICKS) begin
                    n_phase       = urc_pkg::PH_CLEAR;
                    n_phase_ticks = '0;
                    n_elapsed     = '0;
                    n_echo_width  = '0;
                end
            end
            urc_pkg::PH_CLEAR, urc_pkg::PH_RISE, urc_pkg::PH_HIGH: begin
                n_elapsed = s_elapsed_inc;
                if (r_phase == urc_pkg::PH_CLEAR) begin
                    if (!i_echo) begin
                        n_phase = urc_pkg::PH_RISE;
                    end
                end else if (r_phase == urc_pkg::PH_RISE) begin
                    if (i_echo) begin
                        n_phase      = urc_pkg::PH_HIGH;
                        n_echo_width = TIMER_BITS'(1);
                    end
                end else begin
                    if (i_echo) begin
                        n_echo_width = (r_echo_width == '1) ? r_echo_width
                                                            : r_echo_width + 1'b1;
                    end else begin
                        s_done  = 1'b1;
                        s_width = r_echo_width;
                    end
                end
                // falling edge wins over timeout on the same tick
                if (!s_done && (CMP_W'(n_elapsed) >= CMP_W'(r_timeout_us))) begin
                    s_done  = 1'b1;
                    s_width = '0;
                end
            end
            default: begin
                n_phase = urc_pkg::PH_IDLE;
                if (i_start_req) begin
                    n_phase       = urc_pkg::PH_TLOW;
                    n_phase_ticks = urc_pkg::TICK_W'(1);
                    n_status      = urc_pkg::ST_READING;
                end
            end
        endcase

        if (s_done) begin
            n_phase       = urc_pkg::PH_IDLE;
            n_phase_ticks = '0;
            if (s_in_range) begin
                s_res.valid_res      = 1'b1;
                s_res.distance_cm_q4 = s_dist;
                n_failures           = '0;
                n_status             = urc_pkg::ST_READY;
            end else begin
                if (r_failures != urc_pkg::FAIL_MAX) begin
                    n_failures = r_failures + 1'b1;
                end
                n_status = (n_failures > urc_pkg::DISCONNECT_LIMIT)
                         ? urc_pkg::ST_DISCONNECTED : urc_pkg::ST_ERROR;
            end
        end

        case (n_status)
            urc_pkg::ST_DISCONNECTED: s_health = urc_pkg::HEALTH_NONE;
            urc_pkg::ST_ERROR:        s_health = urc_pkg::HEALTH_ERROR;
            default: begin
                if (n_failures >= urc_pkg::HEALTH_FLOOR) begin
                    s_health = urc_pkg::HEALTH_NONE;
                end else begin
                    s_health = urc_pkg::HEALTH_FULL -
                               urc_pkg::HEALTH_W'(n_failures[3:0]) * urc_pkg::HEALTH_STEP;
                end
            end
        endcase

        s_res.done_res      = s_done;
        s_res.sensor_status = n_status;
        s_res.failure_count = n_failures;
        s_res.health_score  = s_health;

        // state only moves on an accepted tick
        if (!s_acc) begin
            n_phase       = r_phase;
            n_phase_ticks = r_phase_ticks;
            n_elapsed     = r_elapsed;
            n_echo_width  = r_echo_width;
            n_failures    = r_failures;
            n_status      = r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= urc_pkg::PH_IDLE;
            r_phase_ticks <= '0;
            r_elapsed     <= '0;
            r_echo_width  <= '0;
            r_failures    <= '0;
            r_status      <= urc_pkg::ST_READY;
        end else begin
            r_phase       <= n_phase;
            r_phase_ticks <= n_phase_ticks;
            r_elapsed     <= n_elapsed;
            r_echo_width  <= n_echo_width;
            r_failures    <= n_failures;
            r_status      <= n_status;
        end
    end

    // Output buffer: skid drains first, so word order is kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (s_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= s_acc;
            end
        end else if (s_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (s_acc) begin
                r_out <= s_res;
            end
        end else if (s_acc) begin
            r_skid <= s_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_trigger        = r_out.trigger;
    assign o_done_res       = r_out.done_res;
    assign o_valid_res      = r_out.valid_res;
    assign o_distance_cm_q4 = r_out.distance_cm_q4;
    assign o_sensor_status  = r_out.sensor_status;
    assign o_failure_count  = r_out.failure_count;
    assign o_health_score   = r_out.health_score;

    `URC_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `URC_ASSERT_IMP(a_valid_is_success, i_clk, i_rst_n, r_out_valid && r_out.valid_res, r_out.done_res && (r_out.sensor_status == urc_pkg::ST_READY) && (r_out.failure_count == '0))
    `URC_ASSERT_IMP(a_fail_status, i_clk, i_rst_n, r_out_valid && r_out.done_res && !r_out.valid_res, (r_out.sensor_status == urc_pkg::ST_ERROR) || (r_out.sensor_status == urc_pkg::ST_DISCONNECTED))
    `URC_ASSERT_IMP(a_dist_only_valid, i_clk, i_rst_n, r_out_valid && (r_out.distance_cm_q4 != '0), r_out.valid_res && (r_out.distance_cm_q4 <= urc_pkg::DIST_MAX))
    `URC_ASSERT_NXT(a_start_from_idle, i_clk, i_rst_n, s_acc && (r_phase == urc_pkg::PH_IDLE) && i_start_req, (r_phase == urc_pkg::PH_TLOW) && (r_status == urc_pkg::ST_READING))

endmodule
